// ----- design/cwfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cwfc_pkg;

	localparam int COEF_IDX_W = 12;
	localparam int VAL_W      = 16;
	localparam int SUM_W      = 38;
	localparam int NSC_W      = 7;
	localparam int SCALE_W    = 6;
	localparam int CNT_W      = 32;
	localparam int PROD_W     = 32;
	localparam int ACC_W      = 48;
	localparam int CFG_IDX_W  = 1;

	localparam logic FUNC_LOAD_COEF = 1'b0;
	localparam logic FUNC_SAMPLE    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_SCALES = 1'b1;

	localparam logic [NSC_W-1:0] NUM_SCALES_RESET = 7'd64;

	localparam logic signed [ACC_W-1:0] SUM_MAX = 48'sh001F_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] SUM_MIN = 48'shFFE0_0000_0000;

	typedef struct packed {
		logic clr;
		logic rd_valid;
	} mac_ctrl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ----- design/cwfc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface cwfc_in_if
	import cwfc_pkg::*;
();
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [COEF_IDX_W-1:0]        coef_index;
	logic signed [VAL_W-1:0]      coef_value;
	logic signed [VAL_W-1:0]      sample;

	modport source (output valid, func, coef_index, coef_value, sample, input ready);
	modport sink (input valid, func, coef_index, coef_value, sample, output ready);
endinterface

interface cwfc_out_if
	import cwfc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 crossed;
	logic [SCALE_W-1:0]   crossing_scale;
	logic [CNT_W-1:0]     scale_count;
	logic [CNT_W-1:0]     crossed_total;

	modport source (output valid, crossed, crossing_scale, scale_count, crossed_total,
		input ready);
	modport sink (input valid, crossed, crossing_scale, scale_count, crossed_total,
		output ready);
endinterface

`default_nettype wire

// ----- design/cwfc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cwfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/cwfc_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cwfc_mac
	import cwfc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mac_ctrl_t               ctrl,
	input  wire logic signed [VAL_W-1:0] coef,
	input  wire logic signed [VAL_W-1:0] samp,
	output logic signed [ACC_W-1:0]      acc,
	output logic                         busy
);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= coef * samp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctrl.rd_valid;
			if (ctrl.clr) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	assign acc  = acc_q;
	assign busy = vld_s1;

endmodule

`default_nettype wire

// ----- design/correlated_walk_first_crossing.sv -----
// Channel  Direction  Fields
// samples  in         func, coef_index, coef_value, sample
// results  out        crossed, crossing_scale, scale_count, crossed_total
//
// A coefficient load is written in its accepting cycle. A walk sample at step i passes
// through the accepting cycle, i + 1 reads of the coefficient and sample memories
// through one multiply-accumulate unit, the read and product pipeline registers, the
// settling of the sum and a threshold check. A path end adds a histogram update.
// Reset clears the step, the histogram valid bits, the total and the output valid flag at once.
// A finished result sits in an output register; a path end waits there while it is full.
`timescale 1ns / 1ps
`default_nettype none

module correlated_walk_first_crossing
	import cwfc_pkg::*;
#(
	parameter int MAX_SCALES = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SUM_W-1:0]     cfg_data,
	cwfc_in_if.sink                   samples,
	cwfc_out_if.source                results
);

	localparam int STEP_W     = $clog2(MAX_SCALES);
	localparam int COEF_DEPTH = MAX_SCALES * (MAX_SCALES + 1) / 2;
	localparam int COEF_AW    = $clog2(COEF_DEPTH);
	localparam int NS_W       = ((STEP_W + 1 > NSC_W) ? STEP_W + 1 : NSC_W) + 1;

	typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_CHECK, ST_HIST} state_t;

	state_t                     state_q;
	logic [STEP_W-1:0]          step_q;
	logic [COEF_AW-1:0]         row_q;
	logic [STEP_W-1:0]          cnt_q;
	logic                       issue_q;
	logic                       rd_vld_q;
	logic signed [SUM_W-1:0]    threshold_q;
	logic [NSC_W-1:0]           num_scales_q;
	logic                       crossed_q;
	logic [MAX_SCALES-1:0]      hist_vld_q;
	logic [CNT_W-1:0]           total_q;
	logic                       out_valid_q;
	logic                       out_crossed_q;
	logic [SCALE_W-1:0]         out_scale_q;
	logic [CNT_W-1:0]           out_count_q;
	logic [CNT_W-1:0]           out_total_q;

	logic                       in_acc;
	logic                       coef_we;
	logic                       samp_we;
	logic                       rd_en;
	logic [COEF_AW-1:0]         coef_raddr;
	logic [VAL_W-1:0]           coef_rdata;
	logic [VAL_W-1:0]           samp_rdata;
	logic                       hist_re;
	logic                       hist_we;
	logic [CNT_W-1:0]           hist_rdata;
	logic [CNT_W-1:0]           hist_cur;
	logic [CNT_W-1:0]           hist_new;
	logic [CNT_W-1:0]           total_new;
	mac_ctrl_t                  mac_ctrl;
	logic signed [ACC_W-1:0]    acc;
	logic                       mac_busy;
	logic signed [SUM_W-1:0]    sum_sat;
	logic                       crossed;
	logic [NS_W-1:0]            ns_raw;
	logic [NS_W-1:0]            ns_eff;
	logic                       more_steps;
	logic                       out_free;
	logic                       mac_done;

	always_comb begin
		in_acc   = samples.valid && samples.ready;
		coef_we  = in_acc && (samples.func == FUNC_LOAD_COEF)
			&& (32'(samples.coef_index) < 32'(COEF_DEPTH));
		samp_we  = in_acc && (samples.func == FUNC_SAMPLE);
		rd_en    = (state_q == ST_MAC) && issue_q;
		coef_raddr = row_q + COEF_AW'(cnt_q);
		mac_ctrl.clr      = samp_we;
		mac_ctrl.rd_valid = rd_vld_q;
		mac_done = !issue_q && !rd_vld_q && !mac_busy;

		if (acc > SUM_MAX) begin
			sum_sat = SUM_W'(SUM_MAX);
		end else if (acc < SUM_MIN) begin
			sum_sat = SUM_W'(SUM_MIN);
		end else begin
			sum_sat = acc[SUM_W-1:0];
		end
		crossed = sum_sat >= threshold_q;

		ns_raw = NS_W'(num_scales_q);
		if (ns_raw == '0) begin
			ns_eff = NS_W'(1);
		end else if (ns_raw > NS_W'(MAX_SCALES)) begin
			ns_eff = NS_W'(MAX_SCALES);
		end else begin
			ns_eff = ns_raw;
		end
		more_steps = (NS_W'(step_q) + NS_W'(1)) < ns_eff;
		out_free   = !out_valid_q || results.ready;
		hist_re    = (state_q == ST_CHECK) && (crossed || !more_steps) && out_free;

		hist_cur  = hist_vld_q[step_q] ? hist_rdata : '0;
		hist_new  = crossed_q ? sat_inc(hist_cur) : hist_cur;
		total_new = crossed_q ? sat_inc(total_q) : total_q;
		hist_we   = (state_q == ST_HIST) && crossed_q;
	end

	assign samples.ready          = (state_q == ST_IDLE);
	assign results.valid          = out_valid_q;
	assign results.crossed        = out_crossed_q;
	assign results.crossing_scale = out_scale_q;
	assign results.scale_count    = out_count_q;
	assign results.crossed_total  = out_total_q;

	cwfc_ram #(.WIDTH(VAL_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (COEF_AW'(samples.coef_index)),
		.wdata (samples.coef_value),
		.re    (rd_en),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	cwfc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SCALES)) u_samp_ram (
		.clk   (clk),
		.we    (samp_we),
		.waddr (step_q),
		.wdata (samples.sample),
		.re    (rd_en),
		.raddr (cnt_q),
		.rdata (samp_rdata)
	);

	cwfc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_SCALES)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (step_q),
		.wdata (hist_new),
		.re    (hist_re),
		.raddr (step_q),
		.rdata (hist_rdata)
	);

	cwfc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.coef   ($signed(coef_rdata)),
		.samp   ($signed(samp_rdata)),
		.acc    (acc),
		.busy   (mac_busy)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_HIST) begin
			out_crossed_q <= crossed_q;
			out_scale_q   <= SCALE_W'(step_q);
			out_count_q   <= hist_new;
			out_total_q   <= total_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			row_q        <= '0;
			cnt_q        <= '0;
			issue_q      <= 1'b0;
			rd_vld_q     <= 1'b0;
			threshold_q  <= '0;
			num_scales_q <= NUM_SCALES_RESET;
			crossed_q    <= 1'b0;
			hist_vld_q   <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_vld_q <= rd_en;
			if (cfg_we) begin
				case (cfg_index)
					CFG_THRESHOLD: threshold_q <= $signed(cfg_data);
					CFG_NUM_SCALES: num_scales_q <= cfg_data[NSC_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (samp_we) begin
						cnt_q   <= '0;
						issue_q <= 1'b1;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (issue_q) begin
						cnt_q <= cnt_q + STEP_W'(1);
						if (cnt_q == step_q) begin
							issue_q <= 1'b0;
						end
					end else if (mac_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!crossed && more_steps) begin
						step_q  <= step_q + STEP_W'(1);
						row_q   <= row_q + COEF_AW'(step_q) + COEF_AW'(1);
						state_q <= ST_IDLE;
					end else if (out_free) begin
						crossed_q <= crossed;
						state_q   <= ST_HIST;
					end
				end
				ST_HIST: begin
					if (crossed_q) begin
						hist_vld_q[step_q] <= 1'b1;
					end
					total_q     <= total_new;
					out_valid_q <= 1'b1;
					step_q      <= '0;
					row_q       <= '0;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_sample_starts_mac: assert property (@(posedge clk) disable iff (!arst_n)
		samp_we |=> (state_q == ST_MAC) && issue_q && (cnt_q == '0))
		else $error("accepted sample did not start the dot product");

	a_hist_into_free_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HIST) |-> !out_valid_q)
		else $error("result written over a pending result");

	a_crossed_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.crossed) |->
			(results.crossed_total != '0) && (results.scale_count != '0))
		else $error("crossed path reported with a zero count");

	a_no_read_past_row: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (cnt_q <= step_q))
		else $error("dot product read beyond the current row");

	a_check_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_CHECK) |-> $past(mac_done))
		else $error("threshold check before the accumulator settled");
`endif

endmodule

`default_nettype wire
